FILE: hw/rtl/vtce_pkg.sv
// Package for the vector terminal coordinate encoder.
// Holds coordinate widths, terminal byte codes and the byte plan type.
// No dependencies.
package vtce_pkg;

  // Coordinate and screen geometry
  localparam int COORD_BITS  = 14;
  localparam int SCREEN_BITS = 9;
  localparam int LOW_BITS    = 5;
  localparam int HIGH_BITS   = SCREEN_BITS - LOW_BITS;

  // Stream widths
  localparam int S_TDATA_W = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int BYTE_W    = 7;
  localparam int M_TDATA_W = ((BYTE_W + 7) / 8) * 8;

  // Command kinds carried in tuser
  localparam logic ACT_MOVE = 1'b0;
  localparam logic ACT_DRAW = 1'b1;

  // Terminal byte codes
  localparam logic [BYTE_W-1:0] GROUP_SEP = 7'o035;
  localparam logic [BYTE_W-1:0] HIGH_TAG  = 7'o040;
  localparam logic [BYTE_W-1:0] LOW_Y_TAG = 7'o140;
  localparam logic [BYTE_W-1:0] LOW_X_TAG = 7'o100;

  // Byte plan for one command
  localparam int MAX_BYTES = 5;
  localparam int IDX_W     = $clog2(MAX_BYTES);

  typedef struct packed {
    logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
    logic [IDX_W-1:0]                 last_idx;
  } plan_t;

  // Command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

endpackage

FILE: hw/rtl/vtce_front.sv
// Front end: accepts commands, scales coordinates and plans the byte list.
// Keeps the last high y, low y and high x bytes sent. Depends on vtce_pkg.
module vtce_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cmd_valid_i,
  input  logic                              cmd_action_i,
  input  logic [vtce_pkg::COORD_BITS-1:0]   cmd_x_i,
  input  logic [vtce_pkg::COORD_BITS-1:0]   cmd_y_i,
  input  logic                              q_full_i,
  output logic                              cmd_ready_o,
  output logic                              push_o,
  output vtce_pkg::plan_t                   plan_o
);

  localparam int BW = vtce_pkg::BYTE_W;

  logic [vtce_pkg::SCREEN_BITS-1:0] sx, sy;
  logic [BW-1:0] hy, ly, hx, lx;
  logic [BW-1:0] sent_hy_q, sent_hy_d, sent_ly_q, sent_ly_d, sent_hx_q, sent_hx_d;
  logic          draw;
  logic [3:0]    en;
  logic [3:0][BW-1:0] cand;
  logic          accept;

  assign cmd_ready_o = !q_full_i;
  assign accept      = cmd_valid_i && !q_full_i;
  assign push_o      = accept;
  assign draw        = (cmd_action_i == vtce_pkg::ACT_DRAW);

  // Scale to screen coordinates and form the address bytes
  assign sx = cmd_x_i[vtce_pkg::COORD_BITS-1 -: vtce_pkg::SCREEN_BITS];
  assign sy = cmd_y_i[vtce_pkg::COORD_BITS-1 -: vtce_pkg::SCREEN_BITS];
  assign hy = vtce_pkg::HIGH_TAG
            | BW'(sy[vtce_pkg::SCREEN_BITS-1 -: vtce_pkg::HIGH_BITS]);
  assign ly = vtce_pkg::LOW_Y_TAG | BW'(sy[vtce_pkg::LOW_BITS-1:0]);
  assign hx = vtce_pkg::HIGH_TAG
            | BW'(sx[vtce_pkg::SCREEN_BITS-1 -: vtce_pkg::HIGH_BITS]);
  assign lx = vtce_pkg::LOW_X_TAG | BW'(sx[vtce_pkg::LOW_BITS-1:0]);

  // Pick which address bytes go out; a move sends all of them
  always_comb begin
    cand = {lx, hx, ly, hy};
    if (draw) begin
      en[0] = (hy != sent_hy_q);
      en[2] = (hx != sent_hx_q);
      en[1] = en[2] || (ly != sent_ly_q);
    end else begin
      en[0] = 1'b1;
      en[1] = 1'b1;
      en[2] = 1'b1;
    end
    en[3] = 1'b1;
  end

  // Pack the chosen bytes in order
  always_comb begin
    logic [vtce_pkg::IDX_W-1:0] pos;
    pos = '0;
    plan_o.bytes = '0;
    if (!draw) begin
      plan_o.bytes[0] = vtce_pkg::GROUP_SEP;
      pos = vtce_pkg::IDX_W'(1);
    end
    for (int i = 0; i < 4; i++) begin
      if (en[i]) begin
        plan_o.bytes[pos] = cand[i];
        pos = pos + vtce_pkg::IDX_W'(1);
      end
    end
    plan_o.last_idx = pos - vtce_pkg::IDX_W'(1);
  end

  // Track the bytes the terminal already holds
  always_comb begin
    sent_hy_d = sent_hy_q;
    sent_ly_d = sent_ly_q;
    sent_hx_d = sent_hx_q;
    if (accept) begin
      if (en[0]) sent_hy_d = hy;
      if (en[1]) sent_ly_d = ly;
      if (en[2]) sent_hx_d = hx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sent_hy_q <= '0;
      sent_ly_q <= '0;
      sent_hx_q <= '0;
    end else begin
      sent_hy_q <= sent_hy_d;
      sent_ly_q <= sent_ly_d;
      sent_hx_q <= sent_hx_d;
    end
  end

endmodule

FILE: hw/rtl/vtce_queue.sv
// Short queue of byte plans between the front and back ends.
// Depth set by vtce_pkg::QDEPTH. Depends on vtce_pkg.
module vtce_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  vtce_pkg::plan_t push_data_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            valid_o,
  output vtce_pkg::plan_t pop_data_o
);

  localparam int PW = vtce_pkg::QPTR_W;
  localparam int CW = vtce_pkg::QCNT_W;

  vtce_pkg::plan_t mem_q [vtce_pkg::QDEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          do_push, do_pop;

  assign full_o     = (count_q == CW'(vtce_pkg::QDEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(vtce_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(vtce_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store entries; payload needs no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: hw/rtl/vtce_back.sv
// Back end: walks one byte plan at a time and sends a byte per cycle while out_ready_i is high.
// Output goes through a register stage. Depends on vtce_pkg.
module vtce_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  vtce_pkg::plan_t               q_data_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  output logic [vtce_pkg::BYTE_W-1:0]   out_byte_o,
  output logic                          out_last_o,
  input  logic                          out_ready_i
);

  localparam int IW = vtce_pkg::IDX_W;

  vtce_pkg::plan_t cur_q, cur_d;
  logic            cur_valid_q, cur_valid_d;
  logic [IW-1:0]   idx_q, idx_d;
  logic            out_valid_q, out_valid_d;
  logic [vtce_pkg::BYTE_W-1:0] out_byte_q, out_byte_d;
  logic            out_last_q, out_last_d;
  logic            slot_free, advance, is_last, finish, pop;

  assign slot_free = !out_valid_q || out_ready_i;
  assign advance   = cur_valid_q && slot_free;
  assign is_last   = (idx_q == cur_q.last_idx);
  assign finish    = advance && is_last;
  assign pop       = q_valid_i && (!cur_valid_q || finish);
  assign q_pop_o   = pop;

  // Load the next plan and step through its bytes
  always_comb begin
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    idx_d       = idx_q;
    if (advance) begin
      idx_d = is_last ? '0 : idx_q + IW'(1);
    end
    if (pop) begin
      cur_d       = q_data_i;
      cur_valid_d = 1'b1;
    end else if (finish) begin
      cur_valid_d = 1'b0;
    end
  end

  // Fill the output stage whenever it is empty or being drained
  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    if (slot_free) begin
      out_valid_d = cur_valid_q;
      out_byte_d  = cur_q.bytes[idx_q];
      out_last_d  = is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule

FILE: hw/rtl/vector_terminal_coordinate_encoder.sv
// Top level of the vector terminal coordinate encoder.
// Ties front end, plan queue and back end. Depends on vtce_pkg and submodules.
//
//  Channel   Dir   tdata (low bit up)                      tuser / tlast
//  s_axis    in    x_coord[13:0], y_coord[13:0], 4'b0      tuser = action
//  m_axis    out   out_byte[6:0], 1'b0                     tlast = last
//
// A command produces 1 to 5 bytes; the output sends one byte per cycle while
// m_axis_tready is high; a move sends 5 bytes and a draw 1 to 4.
// Commands are taken every cycle while the two-entry plan queue has room.
// Reset clears the sent-byte history to zero; no sweep follows.
// Output stalls back up through the queue to s_axis_tready only when full.
module vector_terminal_coordinate_encoder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [vtce_pkg::S_TDATA_W-1:0] s_axis_tdata,  // x_coord, y_coord
  input  logic                           s_axis_tuser,  // action
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [vtce_pkg::M_TDATA_W-1:0] m_axis_tdata,  // out_byte
  output logic                           m_axis_tlast
);

  localparam int CB = vtce_pkg::COORD_BITS;

  logic            push, q_full, q_valid, q_pop;
  vtce_pkg::plan_t plan_in, plan_out;
  logic [vtce_pkg::BYTE_W-1:0] out_byte;

  vtce_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (s_axis_tvalid),
    .cmd_action_i (s_axis_tuser),
    .cmd_x_i      (s_axis_tdata[CB-1:0]),
    .cmd_y_i      (s_axis_tdata[2*CB-1:CB]),
    .q_full_i     (q_full),
    .cmd_ready_o  (s_axis_tready),
    .push_o       (push),
    .plan_o       (plan_in)
  );

  vtce_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (plan_in),
    .pop_i       (q_pop),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .pop_data_o  (plan_out)
  );

  vtce_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (plan_out),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_byte_o  (out_byte),
    .out_last_o  (m_axis_tlast),
    .out_ready_i (m_axis_tready)
  );

  // Pad the byte to the tdata width
  assign m_axis_tdata = vtce_pkg::M_TDATA_W'(out_byte);

endmodule

FILE: tb/vector_terminal_coordinate_encoder_test.sv
// Testbench for the vector terminal coordinate encoder: drives move and draw commands,
// predicts the terminal byte stream and checks each output byte and its tlast flag.
// Depends on vtce_pkg and the vector_terminal_coordinate_encoder RTL.
`timescale 1ns / 100ps

module vector_terminal_coordinate_encoder_test;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD      = 80;
  localparam int DRAIN_CYCLES   = 20;
  localparam int MAX_REPORTS    = 10;
  localparam int SHIFT          = vtce_pkg::COORD_BITS - vtce_pkg::SCREEN_BITS;

  typedef logic [vtce_pkg::COORD_BITS-1:0] coord_t;
  typedef logic [vtce_pkg::BYTE_W-1:0]     code_t;

  typedef struct {
    code_t code;
    logic  last;
  } term_byte_t;

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [vtce_pkg::S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic                           s_axis_tuser  = vtce_pkg::ACT_MOVE;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [vtce_pkg::M_TDATA_W-1:0] m_axis_tdata;
  logic                           m_axis_tlast;

  // Terminal history as the encoder should hold it
  code_t      held_high_y = '0;
  code_t      held_low_y  = '0;
  code_t      held_high_x = '0;
  term_byte_t terminal_bytes_due[$];

  int error_count = 0;
  int idle_cycles = 0;

  // Traffic shaping shared between the test sequence and the receiver
  bit          no_idle       = 1'b0;
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;
  int unsigned stretch_left  = 0;
  logic        stretch_ready = 1'b1;

  vector_terminal_coordinate_encoder DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // x_coord, y_coord, zero fill
    .s_axis_tuser  (s_axis_tuser),   // action
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // out_byte, zero fill
    .m_axis_tlast  (m_axis_tlast)
  );

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Expected byte stream
  function automatic void queue_byte(code_t code, logic last);
    term_byte_t b;
    b.code = code;
    b.last = last;
    terminal_bytes_due.push_back(b);
  endfunction

  // Scale both coordinates, then emit the address bytes the terminal still lacks
  function automatic void predict_terminal_bytes(logic act, coord_t x, coord_t y);
    logic [vtce_pkg::SCREEN_BITS-1:0] sx;
    logic [vtce_pkg::SCREEN_BITS-1:0] sy;
    code_t hy, ly, hx, lx;
    sx = vtce_pkg::SCREEN_BITS'(x >> SHIFT);
    sy = vtce_pkg::SCREEN_BITS'(y >> SHIFT);
    hy = {3'b000, sy[vtce_pkg::SCREEN_BITS-1:vtce_pkg::LOW_BITS]} | vtce_pkg::HIGH_TAG;
    ly = {2'b00, sy[vtce_pkg::LOW_BITS-1:0]} | vtce_pkg::LOW_Y_TAG;
    hx = {3'b000, sx[vtce_pkg::SCREEN_BITS-1:vtce_pkg::LOW_BITS]} | vtce_pkg::HIGH_TAG;
    lx = {2'b00, sx[vtce_pkg::LOW_BITS-1:0]} | vtce_pkg::LOW_X_TAG;
    if (act == vtce_pkg::ACT_MOVE) begin
      queue_byte(vtce_pkg::GROUP_SEP, 1'b0);
      queue_byte(hy, 1'b0);
      queue_byte(ly, 1'b0);
      queue_byte(hx, 1'b0);
      held_high_y = hy;
      held_low_y  = ly;
      held_high_x = hx;
    end else begin
      if (hy != held_high_y) begin
        queue_byte(hy, 1'b0);
        held_high_y = hy;
      end
      // A new high x forces low y out as well
      if (hx != held_high_x) begin
        queue_byte(ly, 1'b0);
        queue_byte(hx, 1'b0);
        held_low_y  = ly;
        held_high_x = hx;
      end else if (ly != held_low_y) begin
        queue_byte(ly, 1'b0);
        held_low_y = ly;
      end
    end
    queue_byte(lx, 1'b1);
  endfunction

  task automatic note_mismatch(string what, int unsigned want, int unsigned got);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("%0t: %s mismatch: expected 0o%0o, got 0o%0o", $realtime, what, want, got);
  endtask

  // Record accepted commands and check each output transaction; sampled mid-cycle
  always @(negedge clk_i) begin
    term_byte_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        predict_terminal_bytes(s_axis_tuser, s_axis_tdata[vtce_pkg::COORD_BITS-1:0],
                               s_axis_tdata[2*vtce_pkg::COORD_BITS-1:vtce_pkg::COORD_BITS]);
      if (m_axis_tvalid && m_axis_tready) begin
        if (terminal_bytes_due.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: unexpected output byte 0o%0o", $realtime,
                     m_axis_tdata[vtce_pkg::BYTE_W-1:0]);
        end else begin
          want = terminal_bytes_due.pop_front();
          if (m_axis_tdata[vtce_pkg::BYTE_W-1:0] !== want.code)
            note_mismatch("out_byte", want.code, m_axis_tdata[vtce_pkg::BYTE_W-1:0]);
          if (m_axis_tlast !== want.last)
            note_mismatch("last", want.last, m_axis_tlast);
        end
      end
    end
  end

  // Watchdog: stop when no transaction happens for too long
  always @(negedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: random ready stretches, a long hold on request, always ready in free run
  always @(posedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (no_idle) begin
      m_axis_tready <= 1'b1;
    end else begin
      if (stretch_left == 0) begin
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
          stretch_ready = 1'b1;
          stretch_left  = $urandom_range(1, 12);
        end else if (r < 92) begin
          stretch_ready = 1'b0;
          stretch_left  = $urandom_range(1, 3);
        end else begin
          stretch_ready = 1'b0;
          stretch_left  = $urandom_range(12, 40);
        end
      end
      stretch_left--;
      m_axis_tready <= stretch_ready;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one command and hold it until the transaction; call at a rising edge
  task automatic send_command(logic act, coord_t x, coord_t y);
    int unsigned gap;
    logic [vtce_pkg::S_TDATA_W-1:0] word;
    logic taken;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    word = '0;
    word[vtce_pkg::COORD_BITS-1:0]                      = x;
    word[2*vtce_pkg::COORD_BITS-1:vtce_pkg::COORD_BITS] = y;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= act;
    do begin
      @(negedge clk_i);
      taken = s_axis_tready;
      @(posedge clk_i);
    end while (!taken);
  endtask

  // Drop valid, then change traffic shaping between edges
  task automatic set_traffic(bit idle_off, bit long_hold);
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    no_idle = idle_off;
    if (long_hold) hold_requests++;
    @(posedge clk_i);
  endtask

  // First command after reset compares against the zero history
  task automatic test_draw_after_reset();
    send_command(vtce_pkg::ACT_DRAW, '0, '0);
  endtask

  task automatic test_moves_at_extremes();
    send_command(vtce_pkg::ACT_MOVE, '0, '0);
    send_command(vtce_pkg::ACT_MOVE, '1, '1);
    send_command(vtce_pkg::ACT_MOVE, '1, '0);
    send_command(vtce_pkg::ACT_MOVE, '0, '1);
  endtask

  // Walk through each draw case: nothing changed, sub-pixel change, low y only,
  // high x only, high y only, everything changed
  task automatic test_draw_byte_selection();
    send_command(vtce_pkg::ACT_MOVE, '0, '0);
    send_command(vtce_pkg::ACT_DRAW, '0, '0);
    send_command(vtce_pkg::ACT_DRAW, 14'd31, 14'd31);
    send_command(vtce_pkg::ACT_DRAW, 14'd32, 14'd32);
    send_command(vtce_pkg::ACT_DRAW, 14'd1056, 14'd32);
    send_command(vtce_pkg::ACT_DRAW, 14'd1056, 14'd1056);
    send_command(vtce_pkg::ACT_DRAW, '1, '1);
    send_command(vtce_pkg::ACT_DRAW, '1, 14'd16000);
    send_command(vtce_pkg::ACT_DRAW, 14'd0, 14'd16000);
    send_command(vtce_pkg::ACT_DRAW, 14'd0, 14'd0);
    send_command(vtce_pkg::ACT_DRAW, 14'd8191, 14'd8192);
  endtask

  function automatic int unsigned step_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) return 0;
    if (r < 60) return $urandom_range(1, 63);
    if (r < 90) return $urandom_range(64, 1023);
    return $urandom_range(1024, 4095);
  endfunction

  // Mostly draws near the pen position, with moves and far jumps mixed in
  task automatic test_random_walk(int count);
    coord_t px, py;
    int unsigned r;
    px = coord_t'($urandom());
    py = coord_t'($urandom());
    send_command(vtce_pkg::ACT_MOVE, px, py);
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        if ($urandom_range(0, 1) != 0) px = px + coord_t'(step_size());
        else                           px = px - coord_t'(step_size());
        if ($urandom_range(0, 1) != 0) py = py + coord_t'(step_size());
        else                           py = py - coord_t'(step_size());
        send_command(vtce_pkg::ACT_DRAW, px, py);
      end else begin
        px = coord_t'($urandom());
        py = coord_t'($urandom());
        send_command(r < 90 ? vtce_pkg::ACT_MOVE : vtce_pkg::ACT_DRAW, px, py);
      end
    end
  endtask

  // Receiver holds off while commands keep coming, so the input must stall
  task automatic test_back_pressure();
    set_traffic(1'b1, 1'b1);
    repeat (20)
      send_command($urandom_range(0, 1) ? vtce_pkg::ACT_DRAW : vtce_pkg::ACT_MOVE,
                   coord_t'($urandom()), coord_t'($urandom()));
    set_traffic(1'b0, 1'b0);
  endtask

  // Full rate on both sides
  task automatic test_free_run();
    set_traffic(1'b1, 1'b0);
    repeat (20)
      send_command($urandom_range(0, 3) == 0 ? vtce_pkg::ACT_MOVE : vtce_pkg::ACT_DRAW,
                   coord_t'($urandom()), coord_t'($urandom()));
    set_traffic(1'b0, 1'b0);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_draw_after_reset();
    test_moves_at_extremes();
    test_draw_byte_selection();
    test_random_walk(102);
    test_back_pressure();
    test_free_run();
    test_random_walk(20);
    // Drain outstanding bytes, then watch for stray output
    s_axis_tvalid <= 1'b0;
    while (terminal_bytes_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
